// ===== rtl/wir_pkg.sv =====
// ----------------------------------------------------------------------------
// wir_pkg
// Shared types, widths and field positions for the wavetable interpolating
// reader.
// ----------------------------------------------------------------------------
`default_nettype none

package wir_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 4096;
    localparam int WAVE_COUNT  = 32;
    localparam int POS_W       = $clog2(TABLE_DEPTH);
    localparam int WAVE_W      = $clog2(WAVE_COUNT);
    localparam int ADDR_W      = WAVE_W + POS_W;
    localparam int STORE_DEPTH = WAVE_COUNT * TABLE_DEPTH;

    // sample and phase format
    localparam int SAMPLE_W  = 24;
    localparam int FRAC_BITS = 16;
    localparam int PHASE_W   = 28;
    localparam int ONE_Q     = 1 << FRAC_BITS;

    // datapath widths
    localparam int DIFF_W  = SAMPLE_W + 1;
    localparam int COEF_W  = FRAC_BITS + 4;
    localparam int CWORK_W = COEF_W + 2;
    localparam int PROD_W  = COEF_W + DIFF_W;
    localparam int ACC_W   = PROD_W + 3;
    localparam int LANES   = 4;

    // result queue
    localparam int OUT_DEPTH = 8;
    localparam int OPTR_W    = $clog2(OUT_DEPTH);
    localparam int OCNT_W    = OPTR_W + 1;

    // s_tdata field positions, lowest bit first
    localparam int WAVE_LSB  = 0;
    localparam int WADDR_LSB = WAVE_LSB + WAVE_W;
    localparam int WDATA_LSB = WADDR_LSB + POS_W;
    localparam int PHASE_LSB = WDATA_LSB + SAMPLE_W;
    localparam int IN_BITS   = PHASE_LSB + PHASE_W;
    localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;

    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_READ  = 1'b1
    } req_type_t;

    typedef enum logic {
        MODE_LINEAR  = 1'b0,
        MODE_HERMITE = 1'b1
    } interp_mode_t;

    // sample store write port
    typedef struct packed {
        logic                en;
        logic [ADDR_W-1:0]   addr;
        logic [SAMPLE_W-1:0] data;
    } ram_wr_t;

    // sample store read addresses, two ports
    typedef struct packed {
        logic [ADDR_W-1:0] addr_a;
        logic [ADDR_W-1:0] addr_b;
    } ram_rd_t;

endpackage

`default_nettype wire

// ===== rtl/wir_sample_ram.sv =====
// ----------------------------------------------------------------------------
// wir_sample_ram
// Sample store: one write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module wir_sample_ram (
    input  wire logic                          aclk,
    input  wire wir_pkg::ram_wr_t              wr,
    input  wire wir_pkg::ram_rd_t              rd,
    output logic [wir_pkg::SAMPLE_W-1:0]       rd_data_a,
    output logic [wir_pkg::SAMPLE_W-1:0]       rd_data_b
);

    logic [wir_pkg::SAMPLE_W-1:0] mem [wir_pkg::STORE_DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // two read ports, read data registered
    always_ff @(posedge aclk) begin
        rd_data_a <= mem[rd.addr_a];
        rd_data_b <= mem[rd.addr_b];
    end

endmodule

`default_nettype wire

// ===== rtl/wavetable_interpolating_reader_core.sv =====
// ----------------------------------------------------------------------------
// wavetable_interpolating_reader_core
// Wavetable store with linear or four-point hermite interpolated reads.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries requests. s_tuser 0 writes one table word
//   (wave_select, write_addr, write_data); s_tuser 1 reads an interpolated
//   sample of table wave_select at phase (12 integer, 16 fraction bits).
//   m_ channel returns one word per read, none per write.
//   cfg_ channel writes interp_mode (0 linear, 1 hermite); the user must write
//   it only while idle, which the block itself does not enforce.
// Flow: writes and linear reads can be taken back to back; a hermite read
//   fetches its four taps through the two read ports, inner pair first.
// Path: a read passes stages s1 to s6 and the result queue to m_tdata.
// Reset: interp_mode returns to hermite and the result queue empties; table
//   contents are undefined until written.
// Stall: results wait in an 8-entry queue; s_tready drops while 8 reads are
//   outstanding, and drops for one cycle after each hermite read.
// ----------------------------------------------------------------------------
`default_nettype none

module wavetable_interpolating_reader_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // request words
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [4:0] wave_select, [16:5] write_addr, [40:17] write_data,
    // [68:41] phase, [71:69] zero
    input  wire logic [wir_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] req_type
    input  wire logic                            s_tuser,
    // result words
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [23:0] sample_out
    output logic [wir_pkg::M_TDATA_W-1:0]        m_tdata,
    // configuration
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic                            cfg_data
);

    localparam int SW = wir_pkg::SAMPLE_W;
    localparam int FB = wir_pkg::FRAC_BITS;
    localparam int CW = wir_pkg::COEF_W;
    localparam int KW = wir_pkg::CWORK_W;
    localparam int DW = wir_pkg::DIFF_W;
    localparam int PW = wir_pkg::PROD_W;
    localparam int AW = wir_pkg::ACC_W;
    localparam int NL = wir_pkg::LANES;

    localparam logic signed [AW-1:0] SAT_HI = AW'((64'd1 << (SW - 1)) - 64'd1);
    localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);

    // request field split
    logic [wir_pkg::WAVE_W-1:0]  in_wave;
    logic [wir_pkg::POS_W-1:0]   in_waddr;
    logic [SW-1:0]               in_wdata;
    logic [wir_pkg::PHASE_W-1:0] in_phase;
    logic [wir_pkg::POS_W-1:0]   in_pos;
    logic [FB-1:0]               in_frac;

    assign in_wave  = s_tdata[wir_pkg::WAVE_LSB +: wir_pkg::WAVE_W];
    assign in_waddr = s_tdata[wir_pkg::WADDR_LSB +: wir_pkg::POS_W];
    assign in_wdata = s_tdata[wir_pkg::WDATA_LSB +: SW];
    assign in_phase = s_tdata[wir_pkg::PHASE_LSB +: wir_pkg::PHASE_W];
    assign in_pos   = in_phase[FB +: wir_pkg::POS_W];
    assign in_frac  = in_phase[FB-1:0];

    // control state
    wir_pkg::interp_mode_t       mode_reg, mode_next;
    logic                        ph2_reg, ph2_next;
    logic [wir_pkg::WAVE_W-1:0]  ph2_wave_reg;
    logic [wir_pkg::POS_W-1:0]   ph2_pos_reg;
    logic [wir_pkg::OCNT_W-1:0]  resv_reg, resv_next;
    logic [wir_pkg::OCNT_W-1:0]  ocnt_reg, ocnt_next;
    logic [wir_pkg::OPTR_W-1:0]  wptr_reg, wptr_next;
    logic [wir_pkg::OPTR_W-1:0]  rptr_reg, rptr_next;

    logic s_accept;
    logic acc_read;
    logic acc_write;
    logic m_pop;

    assign s_accept  = s_tvalid && s_tready;
    assign acc_read  = s_accept && (s_tuser == wir_pkg::REQ_READ);
    assign acc_write = s_accept && (s_tuser == wir_pkg::REQ_WRITE);
    assign m_pop     = m_tvalid && m_tready;

    assign s_tready  = !ph2_reg && (resv_reg < wir_pkg::OCNT_W'(wir_pkg::OUT_DEPTH));
    assign cfg_ready = 1'b1;

    // sample store
    wir_pkg::ram_wr_t ram_wr;
    wir_pkg::ram_rd_t ram_rd;
    logic [SW-1:0]    rd_a;
    logic [SW-1:0]    rd_b;

    always_comb begin
        ram_wr.en   = acc_write;
        ram_wr.addr = {in_wave, in_waddr};
        ram_wr.data = in_wdata;
        if (ph2_reg) begin
            // outer taps of a hermite read
            ram_rd.addr_a = {ph2_wave_reg, ph2_pos_reg - wir_pkg::POS_W'(1)};
            ram_rd.addr_b = {ph2_wave_reg, ph2_pos_reg + wir_pkg::POS_W'(2)};
        end else begin
            // taps at the phase and the next one
            ram_rd.addr_a = {in_wave, in_pos};
            ram_rd.addr_b = {in_wave, in_pos + wir_pkg::POS_W'(1)};
        end
    end

    wir_sample_ram u_ram (
        .aclk      (aclk),
        .wr        (ram_wr),
        .rd        (ram_rd),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    // control next state
    always_comb begin
        mode_next = mode_reg;
        if (cfg_valid && cfg_ready) begin
            mode_next = wir_pkg::interp_mode_t'(cfg_data);
        end
        ph2_next  = acc_read && (mode_reg == wir_pkg::MODE_HERMITE);
        resv_next = resv_reg + wir_pkg::OCNT_W'(acc_read) - wir_pkg::OCNT_W'(m_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= wir_pkg::MODE_HERMITE;
            ph2_reg  <= 1'b0;
            resv_reg <= '0;
        end else begin
            mode_reg <= mode_next;
            ph2_reg  <= ph2_next;
            resv_reg <= resv_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ph2_wave_reg <= in_wave;
            ph2_pos_reg  <= in_pos;
        end
    end

    // ------------------------------------------------------------------
    // interpolation pipeline, one read word per stage
    // ------------------------------------------------------------------
    logic                  s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic                  s4_vld_reg, s5_vld_reg, s6_vld_reg;
    wir_pkg::interp_mode_t s1_mode_reg, s2_mode_reg, s3_mode_reg;
    wir_pkg::interp_mode_t s4_mode_reg, s5_mode_reg, s6_mode_reg;
    logic [FB-1:0]         s1_frac_reg, s2_frac_reg, s3_frac_reg;
    logic [FB-1:0]         s2_mu2_reg, s3_mu2_reg, s3_mu3_reg;
    logic [SW-1:0]         s2_y1_reg, s2_y2_reg;
    logic [SW-1:0]         s3_y0_reg, s3_y1_reg, s3_y2_reg, s3_y3_reg;
    logic signed [CW-1:0]  s4_c_reg [NL];
    logic signed [DW-1:0]  s4_x_reg [NL];
    logic signed [PW-1:0]  s5_p_reg [NL];
    logic signed [AW-1:0]  s6_acc_reg;

    logic [2*FB-1:0]       mu2_full, mu3_full;
    logic signed [CW-1:0]  s4_c_next [NL];
    logic signed [DW-1:0]  s4_x_next [NL];
    logic signed [PW-1:0]  s5_p_next [NL];
    logic signed [AW-1:0]  s6_acc_next;
    logic signed [AW-1:0]  res_shift;
    logic [SW-1:0]         res_next;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg <= acc_read;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
        end
    end

    // squared and cubed fraction
    assign mu2_full = {{FB{1'b0}}, s1_frac_reg} * {{FB{1'b0}}, s1_frac_reg};
    assign mu3_full = {{FB{1'b0}}, s2_mu2_reg} * {{FB{1'b0}}, s2_frac_reg};

    // coefficients and tap operands
    always_comb begin
        logic signed [KW-1:0] f_x, mu2_x, mu3_x;
        logic signed [KW-1:0] a0, a1, a2, a3;
        logic signed [DW-1:0] y0_x, y1_x, y2_x, y3_x;
        f_x   = signed'(KW'(s3_frac_reg));
        mu2_x = signed'(KW'(s3_mu2_reg));
        mu3_x = signed'(KW'(s3_mu3_reg));
        y0_x  = signed'({s3_y0_reg[SW-1], s3_y0_reg});
        y1_x  = signed'({s3_y1_reg[SW-1], s3_y1_reg});
        y2_x  = signed'({s3_y2_reg[SW-1], s3_y2_reg});
        y3_x  = signed'({s3_y3_reg[SW-1], s3_y3_reg});
        a0 = (mu3_x <<< 1) - (mu2_x <<< 1) - mu2_x + signed'(KW'(wir_pkg::ONE_Q));
        a1 = mu3_x - (mu2_x <<< 1) + f_x;
        a2 = mu3_x - mu2_x;
        a3 = (mu2_x <<< 1) + mu2_x - (mu3_x <<< 1);
        if (s3_mode_reg == wir_pkg::MODE_HERMITE) begin
            s4_c_next[0] = CW'(a0 <<< 2);
            s4_c_next[1] = CW'((a1 <<< 1) + a1);
            s4_c_next[2] = CW'((a2 <<< 1) + a2);
            s4_c_next[3] = CW'(a3 <<< 2);
            s4_x_next[0] = y1_x;
            s4_x_next[1] = y2_x - y0_x;
            s4_x_next[2] = y3_x - y1_x;
            s4_x_next[3] = y2_x;
        end else begin
            // linear: sample at the phase is y1, the next one y2
            s4_c_next[0] = signed'(CW'(wir_pkg::ONE_Q));
            s4_c_next[1] = CW'(f_x);
            s4_c_next[2] = '0;
            s4_c_next[3] = '0;
            s4_x_next[0] = y1_x;
            s4_x_next[1] = y2_x - y1_x;
            s4_x_next[2] = '0;
            s4_x_next[3] = '0;
        end
    end

    // one multiplier per lane
    always_comb begin
        for (int k = 0; k < NL; k++) begin
            s5_p_next[k] = s4_c_reg[k] * s4_x_reg[k];
        end
    end

    // sum of lanes with rounding bias
    always_comb begin
        logic signed [AW-1:0] bias;
        if (s5_mode_reg == wir_pkg::MODE_HERMITE) begin
            bias = signed'(AW'(2 * wir_pkg::ONE_Q));
        end else begin
            bias = signed'(AW'(wir_pkg::ONE_Q / 2));
        end
        s6_acc_next = AW'(s5_p_reg[0]) + AW'(s5_p_reg[1])
                    + AW'(s5_p_reg[2]) + AW'(s5_p_reg[3]) + bias;
    end

    // scale down and saturate
    always_comb begin
        if (s6_mode_reg == wir_pkg::MODE_HERMITE) begin
            res_shift = s6_acc_reg >>> (FB + 2);
        end else begin
            res_shift = s6_acc_reg >>> FB;
        end
        if (res_shift > SAT_HI) begin
            res_next = SW'(SAT_HI);
        end else if (res_shift < SAT_LO) begin
            res_next = SW'(SAT_LO);
        end else begin
            res_next = SW'(res_shift);
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        s1_mode_reg <= mode_reg;
        s1_frac_reg <= in_frac;

        s2_mode_reg <= s1_mode_reg;
        s2_frac_reg <= s1_frac_reg;
        s2_mu2_reg  <= mu2_full[FB +: FB];
        s2_y1_reg   <= rd_a;
        s2_y2_reg   <= rd_b;

        s3_mode_reg <= s2_mode_reg;
        s3_frac_reg <= s2_frac_reg;
        s3_mu2_reg  <= s2_mu2_reg;
        s3_mu3_reg  <= mu3_full[FB +: FB];
        s3_y0_reg   <= rd_a;
        s3_y1_reg   <= s2_y1_reg;
        s3_y2_reg   <= s2_y2_reg;
        s3_y3_reg   <= rd_b;

        s4_mode_reg <= s3_mode_reg;
        s4_c_reg    <= s4_c_next;
        s4_x_reg    <= s4_x_next;

        s5_mode_reg <= s4_mode_reg;
        s5_p_reg    <= s5_p_next;

        s6_mode_reg <= s5_mode_reg;
        s6_acc_reg  <= s6_acc_next;
    end

    // ------------------------------------------------------------------
    // result queue
    // ------------------------------------------------------------------
    logic [SW-1:0] oq_mem [wir_pkg::OUT_DEPTH];

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        if (s6_vld_reg) begin
            wptr_next = wptr_reg + wir_pkg::OPTR_W'(1);
        end
        if (m_pop) begin
            rptr_next = rptr_reg + wir_pkg::OPTR_W'(1);
        end
        ocnt_next = ocnt_reg + wir_pkg::OCNT_W'(s6_vld_reg) - wir_pkg::OCNT_W'(m_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            ocnt_reg <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            ocnt_reg <= ocnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s6_vld_reg) begin
            oq_mem[wptr_reg] <= res_next;
        end
    end

    assign m_tvalid = (ocnt_reg != '0);
    assign m_tdata  = wir_pkg::M_TDATA_W'(oq_mem[rptr_reg]);

endmodule

`default_nettype wire
